// ===== rtl/cspu_pkg.sv =====
`default_nettype none

package cspu_pkg;

    // register map of the configuration port
    localparam logic [1:0] CFG_START_POSITION = 2'd0;
    localparam logic [1:0] CFG_SIGNAL_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_INTEL_ORDER    = 2'd2;
    localparam logic [1:0] CFG_SIGNED_SIGNAL  = 2'd3;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 7;

    // reset values of the signal description
    localparam logic [5:0] RST_START_POSITION = 6'd0;
    localparam logic [6:0] RST_SIGNAL_LENGTH  = 7'd8;
    localparam logic       RST_INTEL_ORDER    = 1'b1;
    localparam logic       RST_SIGNED_SIGNAL  = 1'b0;

    // item kinds
    localparam logic KIND_EXTRACT = 1'b0;
    localparam logic KIND_INSERT  = 1'b1;

    // signal description as seen by the datapath
    typedef struct packed {
        logic [5:0] start_position;
        logic [6:0] signal_length;
        logic       intel_order;
        logic       signed_signal;
    } t_cfg;

    // reverse the byte order of a 64-bit word
    function automatic logic [63:0] byte_swap(input logic [63:0] x);
        logic [63:0] y;
        y = '0;
        for (int b = 0; b < 8; b++) begin
            y[8*b +: 8] = x[8*(7-b) +: 8];
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cspu_cfg_regs.sv =====
`default_nettype none

module cspu_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_valid,
    input  wire logic [cspu_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [cspu_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output cspu_pkg::t_cfg                           o_cfg
);

    cspu_pkg::t_cfg r_cfg;
    cspu_pkg::t_cfg n_cfg;

    // decode a register write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                cspu_pkg::CFG_START_POSITION: n_cfg.start_position = i_cfg_data[5:0];
                cspu_pkg::CFG_SIGNAL_LENGTH:  n_cfg.signal_length  = i_cfg_data[6:0];
                cspu_pkg::CFG_INTEL_ORDER:    n_cfg.intel_order    = i_cfg_data[0];
                cspu_pkg::CFG_SIGNED_SIGNAL:  n_cfg.signed_signal  = i_cfg_data[0];
                default:                      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_position <= cspu_pkg::RST_START_POSITION;
            r_cfg.signal_length  <= cspu_pkg::RST_SIGNAL_LENGTH;
            r_cfg.intel_order    <= cspu_pkg::RST_INTEL_ORDER;
            r_cfg.signed_signal  <= cspu_pkg::RST_SIGNED_SIGNAL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/cspu_field_xform.sv =====
`default_nettype none

module cspu_field_xform #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  wire cspu_pkg::t_cfg i_cfg,
    input  wire logic        i_kind,
    input  wire logic [63:0] i_frame_payload,
    input  wire logic [63:0] i_insert_value,
    output logic      [63:0] o_signal_value,
    output logic      [63:0] o_updated_payload
);

    // bits of the word that belong to real payload bytes
    localparam logic [63:0] PayloadMask = (PAYLOAD_BYTES >= 8) ? {64{1'b1}} :
                                          ((64'd1 << (PAYLOAD_BYTES * 8)) - 64'd1);

    logic [6:0]  eff_len;
    logic [63:0] len_mask;
    logic [63:0] top_mask;
    logic [5:0]  moto_first;
    logic [7:0]  moto_shift;
    logic        shift_neg;
    logic [6:0]  shift_amt;
    logic [63:0] pay_valid;
    logic [63:0] ext_src;
    logic [63:0] ext_aligned;
    logic [63:0] ext_raw;
    logic        ext_sign;
    logic [63:0] ext_value;
    logic [63:0] ins_bits;
    logic [63:0] ins_fmask;
    logic [63:0] ins_fdata;
    logic [63:0] fld_mask;
    logic [63:0] fld_data;

    // length saturated to the word, and its low-bit mask
    assign eff_len  = (i_cfg.signal_length > 7'd64) ? 7'd64 : i_cfg.signal_length;
    assign len_mask = (eff_len == 7'd64) ? {64{1'b1}} : ((64'd1 << eff_len) - 64'd1);
    assign top_mask = len_mask ^ (len_mask >> 1);

    // motorola order is a linear field in the byte-swapped word; the msb sits at
    // index 63 - (start ^ 7) there, so the field lsb is at 64 - (start ^ 7) - len
    assign moto_first = i_cfg.start_position ^ 6'd7;
    assign moto_shift = 8'd64 - {2'b00, moto_first} - {1'b0, eff_len};

    // signed alignment amount: non-negative means the field lsb sits at or above bit 0
    always_comb begin
        if (i_cfg.intel_order) begin
            shift_neg = 1'b0;
            shift_amt = {1'b0, i_cfg.start_position};
        end else if (moto_shift[7]) begin
            shift_neg = 1'b1;
            shift_amt = 7'(8'd0 - moto_shift);
        end else begin
            shift_neg = 1'b0;
            shift_amt = moto_shift[6:0];
        end
    end

    // extract: bring the field down to bit 0
    assign pay_valid   = i_frame_payload & PayloadMask;
    assign ext_src     = i_cfg.intel_order ? pay_valid : cspu_pkg::byte_swap(pay_valid);
    assign ext_aligned = shift_neg ? (ext_src << shift_amt) : (ext_src >> shift_amt);
    assign ext_raw     = ext_aligned & len_mask;
    assign ext_sign    = |(ext_raw & top_mask);

    // sign extension from the field length
    always_comb begin
        ext_value = ext_raw;
        if (i_cfg.signed_signal && ext_sign && (eff_len != 7'd64)) begin
            ext_value = ext_raw | ~len_mask;
        end
    end

    // insert: move mask and value up to the field position
    assign ins_bits  = i_insert_value & len_mask;
    assign ins_fmask = shift_neg ? (len_mask >> shift_amt) : (len_mask << shift_amt);
    assign ins_fdata = shift_neg ? (ins_bits >> shift_amt) : (ins_bits << shift_amt);
    assign fld_mask  = (i_cfg.intel_order ? ins_fmask : cspu_pkg::byte_swap(ins_fmask))
                       & PayloadMask;
    assign fld_data  = i_cfg.intel_order ? ins_fdata : cspu_pkg::byte_swap(ins_fdata);

    // result select by item kind
    always_comb begin
        if (i_kind == cspu_pkg::KIND_INSERT) begin
            o_signal_value    = '0;
            o_updated_payload = (i_frame_payload & ~fld_mask) | (fld_data & fld_mask);
        end else begin
            o_signal_value    = ext_value;
            o_updated_payload = i_frame_payload;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/can_signal_pack_unpack.sv =====
`default_nettype none

// CAN signal extract / insert. Each item carries an 8-byte payload (byte 0 in
// bits 7..0), a kind and an insert value; an extract item returns the signal
// (sign-extended when configured signed) with the payload unchanged, an insert
// item returns zero and the payload with the signal bits replaced. Intel order
// takes start_position as the signal lsb, Motorola order as the msb with the
// walk going down a byte and on to bit 7 of the next byte; bits past the last
// payload byte read as zero and are never written. One item is accepted per
// clock while the result side is not stalled; its result passes through an
// input register, the single-pass shift and mask datapath, and the result
// register. Configuration registers are written through their own valid/ready
// port, which is always ready, and must only be written while no item is in
// flight.
module can_signal_pack_unpack #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [cspu_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [cspu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input items
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_kind,
    input  wire logic [63:0]                      i_frame_payload,
    input  wire logic [63:0]                      i_insert_value,
    // result items
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [63:0]                           o_signal_value,
    output logic [63:0]                           o_updated_payload
);

    cspu_pkg::t_cfg cfg;

    logic        r_in_valid;
    logic        r_kind;
    logic [63:0] r_frame_payload;
    logic [63:0] r_insert_value;
    logic        r_out_valid;
    logic [63:0] r_signal_value;
    logic [63:0] r_updated_payload;
    logic [63:0] n_signal_value;
    logic [63:0] n_updated_payload;
    logic        out_free;
    logic        in_free;

    assign o_cfg_ready = 1'b1;

    cspu_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // pipeline flow control
    assign out_free   = !r_out_valid || i_out_ready;
    assign in_free    = !r_in_valid || out_free;
    assign o_in_ready = in_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_kind          <= i_kind;
            r_frame_payload <= i_frame_payload;
            r_insert_value  <= i_insert_value;
        end
    end

    cspu_field_xform #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_field_xform (
        .i_cfg             (cfg),
        .i_kind            (r_kind),
        .i_frame_payload   (r_frame_payload),
        .i_insert_value    (r_insert_value),
        .o_signal_value    (n_signal_value),
        .o_updated_payload (n_updated_payload)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_signal_value    <= n_signal_value;
            r_updated_payload <= n_updated_payload;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_signal_value    = r_signal_value;
    assign o_updated_payload = r_updated_payload;

endmodule

`default_nettype wire

// ===== dv/can_signal_pack_unpack_checker.sv =====
`default_nettype none

// watches the configuration, input and result channels of the signal
// extract / insert block, predicts every result item and compares it
module can_signal_pack_unpack_checker #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             o_cfg_ready,
    input  wire logic [cspu_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [cspu_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_in_valid,
    input  wire logic                             o_in_ready,
    input  wire logic                             i_kind,
    input  wire logic [63:0]                      i_frame_payload,
    input  wire logic [63:0]                      i_insert_value,
    input  wire logic                             o_out_valid,
    input  wire logic                             i_out_ready,
    input  wire logic [63:0]                      o_signal_value,
    input  wire logic [63:0]                      o_updated_payload,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    typedef struct packed {
        logic [63:0] signal_value;
        logic [63:0] updated_payload;
    } t_frame_result;

    cspu_pkg::t_cfg layout;
    t_frame_result  awaited_frames[$];
    t_frame_result  oldest;
    int             mismatches_shown;

    initial begin
        o_fail_count     = 0;
        o_pending        = 0;
        mismatches_shown = 0;
    end

    // a payload bit position that exists in the frame
    function automatic bit on_payload(input int p);
        return p >= 0 && p < PAYLOAD_BYTES * 8 && p < 64;
    endfunction

    // walk the signal bits in Intel or Motorola order and extract or insert
    function automatic t_frame_result apply_signal_layout(input cspu_pkg::t_cfg c,
            input logic kind, input logic [63:0] payload, input logic [63:0] value);
        t_frame_result r;
        int            len;
        int            pos;
        int            bit_pos;
        logic [63:0]   sig;
        logic          b;
        len = (c.signal_length > 7'd64) ? 64 : int'(c.signal_length);
        pos = int'(c.start_position);
        sig = '0;
        r.signal_value    = '0;
        r.updated_payload = payload;
        for (int i = 0; i < len; i++) begin
            bit_pos = c.intel_order ? int'(c.start_position) + i : pos;
            if (kind == cspu_pkg::KIND_EXTRACT) begin
                b = on_payload(bit_pos) ? payload[bit_pos] : 1'b0;
                if (c.intel_order)
                    sig[i] = b;
                else
                    sig = {sig[62:0], b};
            end else if (on_payload(bit_pos)) begin
                r.updated_payload[bit_pos] = c.intel_order ? value[i] : value[len-1-i];
            end
            // motorola: down within the byte, then bit 7 of the next byte
            pos = (pos % 8 == 0) ? pos + 15 : pos - 1;
        end
        if (kind == cspu_pkg::KIND_EXTRACT) begin
            if (c.signed_signal && len > 0 && len < 64 && sig[len-1])
                sig = sig | (~64'd0 << len);
            r.signal_value = sig;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
            input logic [63:0] got);
        if (got !== want) begin
            o_fail_count++;
            if (mismatches_shown < 10) begin
                $display("%s mismatch: expected %h, got %h", field, want, got);
                mismatches_shown++;
            end
        end
    endtask

    // track configuration, predict on input items, compare on result items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            layout.start_position = cspu_pkg::RST_START_POSITION;
            layout.signal_length  = cspu_pkg::RST_SIGNAL_LENGTH;
            layout.intel_order    = cspu_pkg::RST_INTEL_ORDER;
            layout.signed_signal  = cspu_pkg::RST_SIGNED_SIGNAL;
            awaited_frames.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cspu_pkg::CFG_START_POSITION: layout.start_position = i_cfg_data[5:0];
                    cspu_pkg::CFG_SIGNAL_LENGTH:  layout.signal_length  = i_cfg_data[6:0];
                    cspu_pkg::CFG_INTEL_ORDER:    layout.intel_order    = i_cfg_data[0];
                    cspu_pkg::CFG_SIGNED_SIGNAL:  layout.signed_signal  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                awaited_frames.push_back(apply_signal_layout(layout, i_kind,
                                                             i_frame_payload, i_insert_value));
            if (o_out_valid && i_out_ready) begin
                if (awaited_frames.size() == 0) begin
                    o_fail_count++;
                    if (mismatches_shown < 10) begin
                        $display("result item with nothing awaited: signal_value %h payload %h",
                                 o_signal_value, o_updated_payload);
                        mismatches_shown++;
                    end
                end else begin
                    oldest = awaited_frames.pop_front();
                    check_field("signal_value", oldest.signal_value, o_signal_value);
                    check_field("updated_payload", oldest.updated_payload, o_updated_payload);
                end
            end
        end
        o_pending = awaited_frames.size();
    end

endmodule

`default_nettype wire

// ===== dv/can_signal_pack_unpack_test.sv =====
`default_nettype none

module can_signal_pack_unpack_test;

    localparam int PAYLOAD_BYTES = 8;
    localparam int SETTING_COUNT = 36;
    localparam int ITEMS_PER_SETTING = 53;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [cspu_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [cspu_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic                             i_kind;
    logic [63:0]                      i_frame_payload;
    logic [63:0]                      i_insert_value;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic [63:0]                      o_signal_value;
    logic [63:0]                      o_updated_payload;

    int fail_count;
    int pending;
    bit no_idle;
    int extract_items;
    int insert_items;
    int settings_used;

    can_signal_pack_unpack #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_frame_payload(i_frame_payload),
        .i_insert_value(i_insert_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_signal_value(o_signal_value),
        .o_updated_payload(o_updated_payload)
    );

    can_signal_pack_unpack_checker #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_kind(i_kind),
        .i_frame_payload(i_frame_payload),
        .i_insert_value(i_insert_value),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_signal_value(o_signal_value),
        .o_updated_payload(o_updated_payload),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // result side stalls at random outside the steady stretch
    always @(negedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(0, 99) >= 16);
    end

    // hard limit on the run
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    task automatic write_register(input logic [cspu_pkg::CFG_INDEX_W-1:0] idx,
            input logic [cspu_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // write the whole signal description; unused upper data bits carry noise
    task automatic configure(input logic [5:0] start, input logic [6:0] len,
            input logic intel, input logic sign_flag);
        logic [5:0] noise;
        noise = 6'($urandom);
        write_register(cspu_pkg::CFG_START_POSITION, {noise[0], start});
        write_register(cspu_pkg::CFG_SIGNAL_LENGTH, len);
        write_register(cspu_pkg::CFG_INTEL_ORDER, {noise, intel});
        noise = 6'($urandom);
        write_register(cspu_pkg::CFG_SIGNED_SIGNAL, {noise, sign_flag});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_item(input logic kind, input logic [63:0] payload,
            input logic [63:0] value);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_frame_payload <= payload;
        i_insert_value  <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (kind == cspu_pkg::KIND_EXTRACT)
            extract_items++;
        else
            insert_items++;
    endtask

    // stop sending and hold off until every result item is back
    task automatic finish_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic random_setting();
        int         pick;
        logic [6:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            len = 7'($urandom_range(1, 63));
        else if (pick < 80)
            len = 7'd64;
        else if (pick < 87)
            len = 7'd1;
        else if (pick < 92)
            len = 7'd0;
        else
            len = 7'($urandom_range(65, 127));
        configure(6'($urandom_range(0, 63)), len, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic random_item();
        logic [63:0] payload;
        logic [63:0] value;
        int          pick;
        payload = {$urandom, $urandom};
        value   = {$urandom, $urandom};
        pick = $urandom_range(0, 15);
        if (pick == 0)
            payload = '0;
        else if (pick == 1)
            payload = '1;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            value = '0;
        else if (pick == 1)
            value = '1;
        send_item(1'($urandom_range(0, 1)), payload, value);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_kind          = cspu_pkg::KIND_EXTRACT;
        i_frame_payload = '0;
        i_insert_value  = '0;
        i_out_ready     = 1'b0;
        no_idle         = 1'b0;
        extract_items   = 0;
        insert_items    = 0;
        settings_used   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset description: intel byte 0, unsigned
        send_item(cspu_pkg::KIND_EXTRACT, 64'h0123_4567_89AB_CDEF, '0);
        send_item(cspu_pkg::KIND_EXTRACT, '1, '1);
        send_item(cspu_pkg::KIND_INSERT, '0, '1);
        send_item(cspu_pkg::KIND_INSERT, '1, '0);
        finish_burst();

        // intel signal running past the last byte
        configure(6'd60, 7'd16, 1'b1, 1'b1);
        send_item(cspu_pkg::KIND_EXTRACT, '1, '0);
        send_item(cspu_pkg::KIND_INSERT, '0, '1);
        finish_burst();

        // motorola covering the whole frame
        configure(6'd7, 7'd64, 1'b0, 1'b0);
        send_item(cspu_pkg::KIND_EXTRACT, 64'h0123_4567_89AB_CDEF, '0);
        send_item(cspu_pkg::KIND_INSERT, '0, 64'hFEDC_BA98_7654_3210);
        finish_burst();

        // full-width signed needs no extension
        configure(6'd0, 7'd64, 1'b1, 1'b1);
        send_item(cspu_pkg::KIND_EXTRACT, {1'b1, 63'd0}, '0);
        send_item(cspu_pkg::KIND_INSERT, '1, 64'h5555_AAAA_0F0F_F0F0);
        finish_burst();

        // motorola from the top bit, most of the walk off the frame
        configure(6'd63, 7'd64, 1'b0, 1'b1);
        send_item(cspu_pkg::KIND_EXTRACT, '1, '0);
        send_item(cspu_pkg::KIND_INSERT, '0, '1);
        finish_burst();

        // zero length
        configure(6'd5, 7'd0, 1'b1, 1'b1);
        send_item(cspu_pkg::KIND_EXTRACT, '1, '0);
        send_item(cspu_pkg::KIND_INSERT, '0, '1);
        finish_burst();

        // length above 64 saturates
        configure(6'd0, 7'd127, 1'b1, 1'b1);
        send_item(cspu_pkg::KIND_EXTRACT, 64'h8000_0000_0000_0001, '0);
        send_item(cspu_pkg::KIND_INSERT, '0, '1);
        finish_burst();

        // single signed bit, motorola
        configure(6'd0, 7'd1, 1'b0, 1'b1);
        send_item(cspu_pkg::KIND_EXTRACT, 64'h1, '0);
        send_item(cspu_pkg::KIND_INSERT, '1, '0);
        finish_burst();

        // random settings, each followed by a full drain
        for (int s = 0; s < SETTING_COUNT; s++) begin
            no_idle = (s >= 12 && s < 18);
            random_setting();
            for (int n = 0; n < ITEMS_PER_SETTING; n++) random_item();
            finish_burst();
        end
        no_idle = 1'b0;

        repeat (10) @(posedge i_clk);
        $display("run covered %0d extract and %0d insert items over %0d signal settings",
                 extract_items, insert_items, settings_used);
        $display("both byte orders, signed and unsigned, zero, full and saturated lengths");
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== can_signal_pack_unpack.f =====
rtl/cspu_pkg.sv
rtl/cspu_cfg_regs.sv
rtl/cspu_field_xform.sv
rtl/can_signal_pack_unpack.sv
dv/can_signal_pack_unpack_checker.sv
dv/can_signal_pack_unpack_test.sv
